### src/vpt_pkg.sv
// ----------------------------------------------------------------------------
// Vertex projective transform package
// Shared widths, register codes and the pipeline tag type.
// ----------------------------------------------------------------------------
`default_nettype none

package vpt_pkg;

  // Fixed-point format of coefficients and coordinates.
  localparam int FracBits = 16;

  // Field widths.
  localparam int CoefW    = 32;
  localparam int VertW    = 32;
  localparam int ScreenW  = 16;
  localparam int OriginW  = 12;
  localparam int ScaleW   = 31;
  localparam int CfgDataW = 31;
  localparam int CoefIdxW = 4;
  localparam int NumCoef  = 16;

  // Internal widths.
  localparam int ProdW  = CoefW + VertW;      // exact coefficient product
  localparam int HW     = ProdW - FracBits + 2; // homogeneous row sum
  localparam int NdcW   = 32;                 // divided coordinate
  localparam int QBits  = NdcW - 1;           // quotient bits below saturation
  localparam int ShiftR = QBits - FracBits;   // integer part cut for the first step
  localparam int MapW   = ProdW + 1;          // screen mapping sum

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgOriginX = 2'd0,
    CfgOriginY = 2'd1,
    CfgScale   = 2'd2
  } cfg_idx_e;

  // Input item kinds.
  typedef enum logic {
    ActWrite     = 1'b0,
    ActTransform = 1'b1
  } action_e;

  // Control that travels with every pipeline slot.
  typedef struct packed {
    logic valid;
    logic dz;
  } vtx_tag_t;

endpackage

`default_nettype wire

### src/vpt_xform.sv
// ----------------------------------------------------------------------------
// Vertex projective transform: matrix store and row sums
// Holds the 4x4 view matrix and forms the homogeneous x, y and w rows in
// a multiply stage followed by a sum stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vpt_xform (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              wr_i,
  input  wire logic                              xf_i,
  input  wire logic [vpt_pkg::CoefIdxW-1:0]      coef_index_i,
  input  wire logic signed [vpt_pkg::CoefW-1:0]  coef_value_i,
  input  wire logic signed [vpt_pkg::VertW-1:0]  vertex_x_i,
  input  wire logic signed [vpt_pkg::VertW-1:0]  vertex_y_i,
  input  wire logic signed [vpt_pkg::VertW-1:0]  vertex_z_i,
  output logic signed [vpt_pkg::HW-1:0]          hx_o,
  output logic signed [vpt_pkg::HW-1:0]          hy_o,
  output logic signed [vpt_pkg::HW-1:0]          hw_o,
  output vpt_pkg::vtx_tag_t                      tag_o
);
  import vpt_pkg::*;

  logic signed [CoefW-1:0] mat_q [NumCoef];
  logic signed [VertW-1:0] vert [3];

  logic signed [ProdW-1:0] prod_q [3][3];
  logic signed [CoefW-1:0] off_q  [3];
  vtx_tag_t                tag1_q;

  logic signed [HW-1:0]    h_q [3];
  logic signed [ProdW-1:0] sum [3];
  vtx_tag_t                tag2_q;

  assign vert[0] = vertex_x_i;
  assign vert[1] = vertex_y_i;
  assign vert[2] = vertex_z_i;

  // Matrix store, identity after reset, one coefficient per write item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoef; i++) begin
        mat_q[i] <= (i % 5 == 0) ? CoefW'(1 << FracBits) : '0;
      end
    end else if (wr_i) begin
      mat_q[coef_index_i] <= coef_value_i;
    end
  end

  // Multiply stage: rows x, y and w only; the z row is never used.
  for (genvar k = 0; k < 3; k++) begin : g_row
    localparam int Row = (k == 2) ? 3 : k;
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          prod_q[k][c] <= mat_q[Row*4 + c] * vert[c];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        off_q[k] <= mat_q[Row*4 + 3];
      end
    end

    // Sum stage: floor-shifted products plus the translation column.
    always_comb begin
      sum[k] = ProdW'(off_q[k]) + (prod_q[k][0] >>> FracBits)
             + (prod_q[k][1] >>> FracBits) + (prod_q[k][2] >>> FracBits);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        h_q[k] <= sum[k][HW-1:0];
      end
    end
  end

  // Tags for both stages; a zero w is flagged as the sum is registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else if (en_i) begin
      tag1_q.valid <= xf_i;
      tag1_q.dz    <= 1'b0;
      tag2_q.valid <= tag1_q.valid;
      tag2_q.dz    <= (sum[2] == '0);
    end
  end

  assign hx_o  = h_q[0];
  assign hy_o  = h_q[1];
  assign hw_o  = h_q[2];
  assign tag_o = tag2_q;

`ifndef NO_ASSERTIONS
  // A coefficient write lands in the addressed matrix entry.
  a_coef_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |=> mat_q[$past(coef_index_i)] == $past(coef_value_i))
    else $error("coefficient write did not reach the matrix");

  // A write item never produces a slot in the pipeline.
  a_write_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && wr_i && !xf_i) |=> !tag1_q.valid)
    else $error("write item entered the pipeline as a vertex");
`endif

endmodule

`default_nettype wire

### src/vpt_div_lane.sv
// ----------------------------------------------------------------------------
// Vertex projective transform: pipelined fixed-point divider
// Computes n/d in fixed point, truncated toward zero and saturated, one
// restoring quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vpt_div_lane (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic signed [vpt_pkg::HW-1:0]  num_i,
  input  wire logic signed [vpt_pkg::HW-1:0]  den_i,
  input  wire vpt_pkg::vtx_tag_t              tag_i,
  output logic signed [vpt_pkg::NdcW-1:0]     ndc_o,
  output vpt_pkg::vtx_tag_t                   tag_o
);
  import vpt_pkg::*;

  localparam logic [NdcW-1:0] SatMag = NdcW'(1) << QBits;
  localparam logic [NdcW-1:0] PosMax = SatMag - NdcW'(1);

  // Magnitude stage.
  logic [HW-1:0] a_q, b0_q;
  logic          neg0_q;
  vtx_tag_t      taga_q;

  // Step pipeline; entry 0 is the setup stage.
  logic [HW-1:0]    r_q   [QBits+1];
  logic [HW-1:0]    b_q   [QBits+1];
  logic [QBits-1:0] lo_q  [QBits+1];
  logic [QBits-1:0] q_q   [QBits+1];
  logic             neg_q [QBits+1];
  logic             sat_q [QBits+1];
  vtx_tag_t         tag_q [QBits+1];

  logic [HW-1:0] r0;

  // Result stage.
  logic signed [NdcW-1:0] ndc_q;
  logic                   negr_q;
  vtx_tag_t               tagr_q;
  logic [NdcW-1:0]        mag;

  // Absolute values and quotient sign.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= num_i[HW-1] ? HW'(-num_i) : HW'(num_i);
      b0_q   <= den_i[HW-1] ? HW'(-den_i) : HW'(den_i);
      neg0_q <= num_i[HW-1] ^ den_i[HW-1];
    end
  end

  // Setup: the integer part decides saturation and seeds the remainder.
  assign r0 = a_q >> ShiftR;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= r0;
      b_q[0]   <= b0_q;
      lo_q[0]  <= {a_q[ShiftR-1:0], {FracBits{1'b0}}};
      q_q[0]   <= '0;
      neg_q[0] <= neg0_q;
      sat_q[0] <= (r0 >= b0_q);
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar i = 0; i < QBits; i++) begin : g_step
    logic [HW:0] trial;
    logic        take;
    assign trial = {r_q[i], lo_q[i][QBits-1]};
    assign take  = (trial >= {1'b0, b_q[i]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i+1]   <= take ? HW'(trial - {1'b0, b_q[i]}) : trial[HW-1:0];
        b_q[i+1]   <= b_q[i];
        lo_q[i+1]  <= {lo_q[i][QBits-2:0], 1'b0};
        q_q[i+1]   <= {q_q[i][QBits-2:0], take};
        neg_q[i+1] <= neg_q[i];
        sat_q[i+1] <= sat_q[i];
      end
    end
  end

  // Sign and saturation of the quotient.
  assign mag = sat_q[QBits] ? SatMag : {1'b0, q_q[QBits]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      negr_q <= neg_q[QBits];
      if (neg_q[QBits]) begin
        ndc_q <= -$signed(mag);
      end else begin
        ndc_q <= $signed(sat_q[QBits] ? PosMax : mag);
      end
    end
  end

  // Tags travel in step with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taga_q <= '0;
      tagr_q <= '0;
      for (int j = 0; j <= QBits; j++) begin
        tag_q[j] <= '0;
      end
    end else if (en_i) begin
      taga_q   <= tag_i;
      tag_q[0] <= taga_q;
      for (int j = 0; j < QBits; j++) begin
        tag_q[j+1] <= tag_q[j];
      end
      tagr_q <= tag_q[QBits];
    end
  end

  assign ndc_o = ndc_q;
  assign tag_o = tagr_q;

`ifndef NO_ASSERTIONS
  // A positive quotient never wraps into the sign bit.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tagr_q.valid && !negr_q) |-> !ndc_q[NdcW-1])
    else $error("positive quotient overflowed");

  // Without saturation the remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag_q[QBits].valid && !tag_q[QBits].dz && !sat_q[QBits])
      |-> (r_q[QBits] < b_q[QBits]))
    else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

### src/vpt_screen_map.sv
// ----------------------------------------------------------------------------
// Vertex projective transform: screen mapping lane
// Scales a divided coordinate, adds or subtracts it from the screen origin,
// truncates toward zero and saturates to a 16-bit pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module vpt_screen_map (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              flip_i,
  input  wire logic [vpt_pkg::OriginW-1:0]       origin_i,
  input  wire logic [vpt_pkg::ScaleW-1:0]        scale_i,
  input  wire logic signed [vpt_pkg::NdcW-1:0]   ndc_i,
  input  wire vpt_pkg::vtx_tag_t                 tag_i,
  output logic signed [vpt_pkg::ScreenW-1:0]     pix_o,
  output vpt_pkg::vtx_tag_t                      tag_o
);
  import vpt_pkg::*;

  localparam int PixShift = 2 * FracBits;
  localparam logic signed [MapW-1:0] Bias   = (MapW'(1) << PixShift) - MapW'(1);
  localparam logic signed [MapW-1:0] PixMax = MapW'((1 << (ScreenW-1)) - 1);
  localparam logic signed [MapW-1:0] PixMin = -PixMax - MapW'(1);

  logic signed [ProdW-1:0]   prod_q;
  logic signed [ScaleW:0]    scale_s;
  logic signed [MapW-1:0]    base;
  logic signed [MapW-1:0]    total_q;
  logic signed [MapW-1:0]    trunc;
  logic signed [ScreenW-1:0] pix_q;
  vtx_tag_t                  tag1_q, tag2_q, tag3_q;

  // Scale times coordinate, exact.
  assign scale_s = $signed({1'b0, scale_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= scale_s * ndc_i;
    end
  end

  // Origin in the doubled fraction format, then add or subtract.
  assign base = $signed(MapW'(origin_i) << PixShift);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      total_q <= flip_i ? base - MapW'(prod_q) : base + MapW'(prod_q);
    end
  end

  // Truncate toward zero, saturate, and force zero when w was zero.
  assign trunc = $signed(total_q + (total_q[MapW-1] ? Bias : '0)) >>> PixShift;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (tag2_q.dz) begin
        pix_q <= '0;
      end else if (trunc > PixMax) begin
        pix_q <= PixMax[ScreenW-1:0];
      end else if (trunc < PixMin) begin
        pix_q <= PixMin[ScreenW-1:0];
      end else begin
        pix_q <= trunc[ScreenW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  assign pix_o = pix_q;
  assign tag_o = tag3_q;

endmodule

`default_nettype wire

### src/vertex_projective_transform_core.sv
// ----------------------------------------------------------------------------
// Vertex projective transform core
// Transforms model vertices by a stored 4x4 matrix, divides by w and maps
// the result to 16-bit screen pixels.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one item per handshake: either a coefficient
// write (action 0) that loads one matrix entry and gives no result, or a
// vertex (action 1) that gives one result item on the output channel.
// The configuration port sets the screen origin and scale; write it only
// while no vertex is in flight.
// One item is accepted every cycle unless the pipeline holds for a stall.
// The depth is set by the divider, which resolves one quotient bit per
// stage over 31 stages, plus two matrix stages, three divider setup and
// result stages, and three mapping stages.
// A coefficient write takes effect for every vertex accepted after it.
// Reset loads the identity matrix, origin 400 by 300 and scale 4.0, and
// empties the pipeline. When the receiver stalls while a result waits,
// the whole pipeline holds and in_stall_o rises until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_projective_transform_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration port.
  input  wire logic                              cfg_we_i,
  input  wire logic [1:0]                        cfg_index_i,
  input  wire logic [vpt_pkg::CfgDataW-1:0]      cfg_wdata_i,
  // Input channel.
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              action_i,
  input  wire logic [vpt_pkg::CoefIdxW-1:0]      coef_index_i,
  input  wire logic signed [vpt_pkg::CoefW-1:0]  coef_value_i,
  input  wire logic signed [vpt_pkg::VertW-1:0]  vertex_x_i,
  input  wire logic signed [vpt_pkg::VertW-1:0]  vertex_y_i,
  input  wire logic signed [vpt_pkg::VertW-1:0]  vertex_z_i,
  // Output channel.
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [vpt_pkg::ScreenW-1:0]     screen_x_o,
  output logic signed [vpt_pkg::ScreenW-1:0]     screen_y_o,
  output logic                                   div_by_zero_o
);
  import vpt_pkg::*;

  logic [OriginW-1:0] origin_x_q, origin_y_q;
  logic [ScaleW-1:0]  scale_q;

  logic en, accept, wr, xf;

  logic signed [HW-1:0]   hx, hy, hw;
  vtx_tag_t               tag_h;
  logic signed [NdcW-1:0] ndc_x, ndc_y;
  vtx_tag_t               tag_dx, tag_dy, tag_mx, tag_my;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= OriginW'(400);
      origin_y_q <= OriginW'(300);
      scale_q    <= ScaleW'(262144);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgOriginX: origin_x_q <= cfg_wdata_i[OriginW-1:0];
        CfgOriginY: origin_y_q <= cfg_wdata_i[OriginW-1:0];
        CfgScale:   scale_q    <= cfg_wdata_i[ScaleW-1:0];
        default:    ;
      endcase
    end
  end

  // The pipeline moves whenever the output slot is empty or being taken.
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;
  assign wr         = accept && (action_e'(action_i) == ActWrite);
  assign xf         = accept && (action_e'(action_i) == ActTransform);

  // Matrix store and row sums.
  vpt_xform u_xform (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .wr_i         (wr),
    .xf_i         (xf),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .vertex_x_i   (vertex_x_i),
    .vertex_y_i   (vertex_y_i),
    .vertex_z_i   (vertex_z_i),
    .hx_o         (hx),
    .hy_o         (hy),
    .hw_o         (hw),
    .tag_o        (tag_h)
  );

  // Perspective divide, one lane per coordinate.
  vpt_div_lane u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .num_i  (hx),
    .den_i  (hw),
    .tag_i  (tag_h),
    .ndc_o  (ndc_x),
    .tag_o  (tag_dx)
  );

  vpt_div_lane u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .num_i  (hy),
    .den_i  (hw),
    .tag_i  (tag_h),
    .ndc_o  (ndc_y),
    .tag_o  (tag_dy)
  );

  // Screen mapping; the y axis is flipped.
  vpt_screen_map u_map_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .flip_i   (1'b0),
    .origin_i (origin_x_q),
    .scale_i  (scale_q),
    .ndc_i    (ndc_x),
    .tag_i    (tag_dx),
    .pix_o    (screen_x_o),
    .tag_o    (tag_mx)
  );

  vpt_screen_map u_map_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .flip_i   (1'b1),
    .origin_i (origin_y_q),
    .scale_i  (scale_q),
    .ndc_i    (ndc_y),
    .tag_i    (tag_dy),
    .pix_o    (screen_y_o),
    .tag_o    (tag_my)
  );

  assign out_valid_o   = tag_mx.valid && tag_my.valid;
  assign div_by_zero_o = tag_mx.dz;

`ifndef NO_ASSERTIONS
  // A zero w always gives a zero pixel pair.
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && div_by_zero_o) |-> (screen_x_o == '0 && screen_y_o == '0))
    else $error("zero w result has nonzero coordinates");

  // Both lanes carry the same slot.
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag_mx == tag_my))
    else $error("coordinate lanes out of step");
`endif

endmodule

`default_nettype wire

### bench/tb_vertex_projective_transform_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex projective transform core testbench
// Sends coefficient writes and vertices with random gaps and back-pressure.
// Each vertex is projected in a behavioral model of the matrix product,
// perspective divide and screen mapping. The expected pixel and zero-w flag
// are queued and compared field by field with each result item.
// ----------------------------------------------------------------------------
module tb_vertex_projective_transform_core;
  import vpt_pkg::*;

  localparam int  Latency    = 39;
  localparam int  SettleCyc  = Latency + 12;
  localparam int  HoldCyc    = 300;
  localparam int  CycleLimit = 400000;
  localparam longint One     = 64'sd65536;

  typedef struct {
    logic signed [ScreenW-1:0] px;
    logic signed [ScreenW-1:0] py;
    logic                      dz;
  } pixel_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [1:0]                        cfg_index_i;
  logic [CfgDataW-1:0]               cfg_wdata_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic                              action_i;
  logic [CoefIdxW-1:0]               coef_index_i;
  logic signed [CoefW-1:0]           coef_value_i;
  logic signed [VertW-1:0]           vertex_x_i;
  logic signed [VertW-1:0]           vertex_y_i;
  logic signed [VertW-1:0]           vertex_z_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic signed [ScreenW-1:0]         screen_x_o;
  logic signed [ScreenW-1:0]         screen_y_o;
  logic                              div_by_zero_o;

  // Shadow of the block's state.
  longint mat[NumCoef];
  longint org_x, org_y, zoom;

  pixel_t pixel_q[$];
  int     err_cnt;
  int     cycle_cnt;
  bit     tx_idle;
  bit     rx_idle;
  bit     hold_req;

  vertex_projective_transform_core u_top (.*);

  always #1 clk_i = ~clk_i;

  // Run-length guard.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Q16.16 quotient, truncated toward zero, saturated to 32 bits.
  function automatic longint div_q(longint n, longint d);
    bit neg;
    longint unsigned a, b, qi, r, mag;
    int i;
    neg = (n < 0) != (d < 0);
    a   = (n < 0) ? -n : n;
    b   = (d < 0) ? -d : d;
    qi  = a / b;
    if (qi >= (64'd1 << (31 - FracBits))) begin
      mag = 64'd1 << 31;
    end else begin
      r   = a % b;
      mag = qi;
      for (i = 0; i < FracBits; i++) begin
        r   = r << 1;
        mag = mag << 1;
        if (r >= b) begin
          r   = r - b;
          mag = mag | 64'd1;
        end
      end
    end
    if (neg) return -longint'(mag);
    if (mag > 64'h7fff_ffff) mag = 64'h7fff_ffff;
    return longint'(mag);
  endfunction

  // Origin plus or minus zoom times the divided coordinate, as a pixel.
  function automatic logic signed [ScreenW-1:0] map_pixel(longint org, longint ndc, bit flip);
    longint base, prod, total, p;
    base  = org <<< (2 * FracBits);
    prod  = zoom * ndc;
    total = flip ? base - prod : base + prod;
    p     = (total >= 0) ? (total >>> (2 * FracBits)) : -((-total) >>> (2 * FracBits));
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p[ScreenW-1:0];
  endfunction

  // Updates the matrix or queues the projected vertex for one accepted item.
  task automatic project_item(action_e act, logic [3:0] idx, logic signed [31:0] cv,
                              logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
    longint v[3];
    longint h[4];
    pixel_t res;
    if (act == ActWrite) begin
      mat[idx] = longint'(cv);
    end else begin
      v[0] = longint'(x);
      v[1] = longint'(y);
      v[2] = longint'(z);
      for (int r = 0; r < 4; r++) begin
        h[r] = mat[r * 4 + 3];
        for (int c = 0; c < 3; c++) h[r] += (mat[r * 4 + c] * v[c]) >>> FracBits;
      end
      if (h[3] == 0) begin
        res.px = '0;
        res.py = '0;
        res.dz = 1'b1;
      end else begin
        res.px = map_pixel(org_x, div_q(h[0], h[3]), 1'b0);
        res.py = map_pixel(org_y, div_q(h[1], h[3]), 1'b1);
        res.dz = 1'b0;
      end
      pixel_q.insert(pixel_q.size(), res);
    end
  endtask

  // Offers one item after a random gap and waits for its acceptance.
  task automatic send_item(action_e act, logic [3:0] idx, logic [31:0] cv,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int  gap;
    bit  took;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    coef_index_i <= idx;
    coef_value_i <= cv;
    vertex_x_i   <= x;
    vertex_y_i   <= y;
    vertex_z_i   <= z;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    project_item(act, idx, cv, x, y, z);
  endtask

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_item(ActTransform, 4'($urandom), $urandom, x, y, z);
  endtask

  task automatic send_coef(logic [3:0] idx, logic [31:0] cv);
    send_item(ActWrite, idx, cv, $urandom, $urandom, $urandom);
  endtask

  // Lowers valid and waits until every queued result has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgOriginX: org_x = data & 12'hfff;
      CfgOriginY: org_y = data & 12'hfff;
      CfgScale:   zoom  = data;
      default: ;
    endcase
  endtask

  // Coordinate or coefficient: mostly a modest Q16.16 value, sometimes any word.
  function automatic logic [31:0] rand_word(int mag_log2);
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2 << mag_log2) - (1 << mag_log2);
    return $urandom;
  endfunction

  task automatic load_identity();
    for (int i = 0; i < NumCoef; i++) send_coef(4'(i), (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
  endtask

  // Random coefficient writes, some to the perspective row, mixed with random vertices.
  task automatic random_burst(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) send_coef(4'($urandom), rand_word(18));
      else if (sel < 16) send_coef(4'(12 + $urandom_range(0, 3)), rand_word(14));
      else send_vertex(rand_word(20), rand_word(20), rand_word(20));
    end
  endtask

  // Extremes of the fields, zero w, saturation and ignored fields.
  task automatic test_directed();
    send_vertex(32'h0, 32'h0, 32'h0);
    send_vertex(32'h0001_0000, 32'hffff_0000, 32'h0);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff);
    // Empty w row makes every vertex a zero-w case.
    send_coef(4'd15, 32'h0);
    send_vertex(32'h0, 32'h0, 32'h0);
    send_vertex(32'h0005_0000, 32'h0003_0000, 32'h0);
    // Tiny w gives quotients that saturate both ways.
    send_coef(4'd14, 32'h1);
    send_vertex(32'h0064_0000, 32'hff9c_0000, 32'h0001_0000);
    send_vertex(32'hff9c_0000, 32'h0064_0000, 32'h0001_0000);
    // Negative w.
    send_coef(4'd14, 32'hffff_0000);
    send_vertex(32'h0003_0000, 32'h0001_8000, 32'h0002_0000);
    send_coef(4'd0, 32'h7fff_ffff);
    send_coef(4'd5, 32'h8000_0000);
    send_vertex(32'h0000_8000, 32'h0000_4000, 32'hfffe_0000);
    send_item(ActTransform, 4'hf, 32'hffff_ffff, 32'h0001_0000, 32'h0, 32'hffff_0000);
    send_item(ActWrite, 4'h3, 32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_vertex(32'h0002_0000, 32'h0002_0000, 32'hffff_0000);
    drain();
    load_identity();
    drain();
  endtask

  // Several screen settings, the extremes and a zero zoom among them.
  task automatic test_screen_settings();
    logic [CfgDataW-1:0] ox[5] = '{31'd0, 31'h7fff_ffff, 31'd4095, 31'd1234, 31'd400};
    logic [CfgDataW-1:0] oy[5] = '{31'd4095, 31'd0, 31'h7fff_f000, 31'd77, 31'd300};
    logic [CfgDataW-1:0] sc[5] = '{31'd1, 31'h7fff_ffff, 31'd0, 31'h0002_8000, 31'd262144};
    for (int s = 0; s < 5; s++) begin
      write_cfg(CfgOriginX, ox[s]);
      write_cfg(CfgOriginY, oy[s]);
      write_cfg(CfgScale, sc[s]);
      random_burst(40);
      drain();
    end
  endtask

  // Long receiver hold while items keep coming, so the input stalls.
  task automatic test_backpressure();
    tx_idle  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 120; i++) send_vertex(rand_word(18), rand_word(18), rand_word(18));
    tx_idle = 1'b1;
    drain();
  endtask

  // Random items, with stretches where neither side idles.
  task automatic test_random();
    for (int p = 0; p < 5; p++) begin
      tx_idle = (p != 2);
      rx_idle = (p != 2) && (p != 4);
      random_burst(100);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    drain();
  endtask

  // Receiver: random stall before each result, or a long hold when asked.
  initial begin
    int  n;
    bit  took;
    out_stall_i = 1'b0;
    forever begin
      n = rx_idle ? $urandom_range(0, 9) : 0;
      if (hold_req) begin
        n        = HoldCyc;
        hold_req = 1'b0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        took = out_valid_o;
        @(posedge clk_i);
      end while (!took);
    end
  end

  // Result checker, sampled mid-cycle where everything is stable.
  always @(negedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_q.size() == 0) begin
        $error("result with no vertex pending: screen_x %0d screen_y %0d",
               screen_x_o, screen_y_o);
        err_cnt++;
      end else begin
        want = pixel_q.pop_front();
        if (screen_x_o !== want.px) begin
          $error("screen_x: expected %0d, got %0d", want.px, screen_x_o);
          err_cnt++;
        end
        if (screen_y_o !== want.py) begin
          $error("screen_y: expected %0d, got %0d", want.py, screen_y_o);
          err_cnt++;
        end
        if (div_by_zero_o !== want.dz) begin
          $error("div_by_zero: expected %0b, got %0b", want.dz, div_by_zero_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CfgOriginX;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    action_i     = ActWrite;
    coef_index_i = '0;
    coef_value_i = '0;
    vertex_x_i   = '0;
    vertex_y_i   = '0;
    vertex_z_i   = '0;
    err_cnt      = 0;
    cycle_cnt    = 0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    hold_req     = 1'b0;
    org_x        = 400;
    org_y        = 300;
    zoom         = 262144;
    for (int i = 0; i < NumCoef; i++) mat[i] = (i % 5 == 0) ? One : 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_screen_settings();
    test_backpressure();
    test_random();

    if (err_cnt == 0 && pixel_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
